// ===== src/tmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared field widths, register indexes and function codes of the tile-map
// window fetcher.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    localparam int TILE_W   = 9;   // tile width / height registers
    localparam int MAP_W    = 13;  // map size registers
    localparam int VIEW_W   = 13;  // view size registers
    localparam int GRID_W   = 64;  // packed tileset grid register
    localparam int CAM_W    = 20;  // camera position
    localparam int ID_W     = 15;  // tile id
    localparam int INDEX_W  = 24;  // map index
    localparam int SRC_W    = 16;  // source pixel position
    localparam int DST_W    = 13;  // destination pixel position
    localparam int SET_W    = 2;   // tileset select
    localparam int CNT_W    = 12;  // visible tiles per axis
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_WIDTH   = 3'd0,
        REG_TILE_HEIGHT  = 3'd1,
        REG_MAP_COLUMNS  = 3'd2,
        REG_MAP_ROWS     = 3'd3,
        REG_VIEW_WIDTH   = 3'd4,
        REG_VIEW_HEIGHT  = 3'd5,
        REG_TILESET_GRID = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_TILE  = 1'b1
    } func_t;

endpackage

// ===== src/tmwf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tmwf_cfg_if
// Register write channel of the tile-map window fetcher.
// ----------------------------------------------------------------------------
interface tmwf_cfg_if;

    logic                            valid;
    logic                            ready;
    logic [tmwf_pkg::CFG_IDX_W-1:0]  index;
    logic [tmwf_pkg::GRID_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

// ===== src/tmwf_in_if.sv =====
// ----------------------------------------------------------------------------
// tmwf_in_if
// Request channel: frame start with camera position, or a delivered tile id.
// ----------------------------------------------------------------------------
interface tmwf_in_if;

    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [tmwf_pkg::CAM_W-1:0]  camera_x;
    logic [tmwf_pkg::CAM_W-1:0]  camera_y;
    logic [tmwf_pkg::ID_W-1:0]   tile_id;

    modport source (output valid, func, camera_x, camera_y, tile_id, input ready);
    modport sink   (input valid, func, camera_x, camera_y, tile_id, output ready);

endinterface

// ===== src/tmwf_out_if.sv =====
// ----------------------------------------------------------------------------
// tmwf_out_if
// Draw command channel of the tile-map window fetcher.
// ----------------------------------------------------------------------------
interface tmwf_out_if;

    logic                          valid;
    logic                          ready;
    logic [tmwf_pkg::INDEX_W-1:0]  map_index;
    logic                          draw;
    logic [tmwf_pkg::SET_W-1:0]    tileset_select;
    logic [tmwf_pkg::SRC_W-1:0]    source_x;
    logic [tmwf_pkg::SRC_W-1:0]    source_y;
    logic [tmwf_pkg::DST_W-1:0]    dest_x;
    logic [tmwf_pkg::DST_W-1:0]    dest_y;
    logic                          frame_done;

    modport source (output valid, map_index, draw, tileset_select, source_x, source_y,
                    dest_x, dest_y, frame_done, input ready);
    modport sink   (input valid, map_index, draw, tileset_select, source_x, source_y,
                    dest_x, dest_y, frame_done, output ready);

endinterface

// ===== src/tile_map_window_fetch.sv =====
// ----------------------------------------------------------------------------
// tile_map_window_fetch
// Tile-map background fetcher: turns a camera position into a walk over the
// visible map window and each tile id delivered in a frame into one draw command.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  cfg      in   valid/ready    index, data (register write)
//  item     in   valid/ready    func, camera_x, camera_y, tile_id
//  result   out  valid/ready    map_index, draw, tileset_select, source_x/y,
//                               dest_x/y, frame_done
//
//  Start request: view size in tiles, then first map index from camera y and x;
//  13 + 13 + 20 + 20 steps in the shared radix-2 divider. Tile request: an
//  empty id skips the search, an unmatched id probes all NUM_TILESETS entries,
//  a hit divides for its source position. Reset loads the default registers
//  with no frame running; a tile request outside a frame is taken and dropped.
//  item is ready only while idle; a stalled result holds the next request.
// ----------------------------------------------------------------------------
module tile_map_window_fetch #(
    parameter int NUM_TILESETS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    tmwf_cfg_if.sink     cfg,
    tmwf_in_if.sink      item,
    tmwf_out_if.source   result
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_VCOL_MUL = 14'b00000000000010,
        ST_VCOL     = 14'b00000000000100,
        ST_VROW_MUL = 14'b00000000001000,
        ST_VROW     = 14'b00000000010000,
        ST_IDX_MUL  = 14'b00000000100000,
        ST_IDX_ADD  = 14'b00000001000000,
        ST_CNT_MUL  = 14'b00000010000000,
        ST_SEARCH   = 14'b00000100000000,
        ST_SRC_X    = 14'b00001000000000,
        ST_SRC_Y    = 14'b00010000000000,
        ST_ADVANCE  = 14'b00100000000000,
        ST_DIVIDE   = 14'b01000000000000,
        ST_DONE     = 14'b10000000000000
    } state_t;

    localparam int CAM_W   = tmwf_pkg::CAM_W;
    localparam int TILE_W  = tmwf_pkg::TILE_W;
    localparam int INDEX_W = tmwf_pkg::INDEX_W;
    localparam int CNT_W   = tmwf_pkg::CNT_W;
    localparam int DST_W   = tmwf_pkg::DST_W;
    localparam int SRC_W   = tmwf_pkg::SRC_W;
    localparam int SET_W   = tmwf_pkg::SET_W;
    localparam int ID_W    = tmwf_pkg::ID_W;
    localparam int VIEW_W  = tmwf_pkg::VIEW_W;
    localparam int MAP_W   = tmwf_pkg::MAP_W;
    localparam int MUL_A_W = CAM_W;
    localparam int MUL_B_W = MAP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DCNT_W  = $clog2(CAM_W + 1);

    // configuration
    logic [TILE_W-1:0]           tile_width_reg, tile_height_reg;
    logic [MAP_W-1:0]            map_columns_reg, map_rows_reg;
    logic [VIEW_W-1:0]           view_width_reg, view_height_reg;
    logic [tmwf_pkg::GRID_W-1:0] tileset_grid_reg;
    logic [TILE_W-1:0]           tw_eff, th_eff;

    // sequencer and frame state
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic                active_reg, active_next;
    logic [INDEX_W-1:0]  fetch_pos_reg, fetch_pos_next;
    logic [INDEX_W-1:0]  tiles_left_reg, tiles_left_next;
    logic [CNT_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]    vis_cols_reg, vis_cols_next;
    logic [DST_W-1:0]    screen_x_reg, screen_x_next;
    logic [DST_W-1:0]    screen_y_reg, screen_y_next;
    logic                out_valid_reg, out_valid_next;

    // working data
    logic [CAM_W-1:0]    cam_x_reg, cam_x_next;
    logic [CAM_W-1:0]    cam_y_reg, cam_y_next;
    logic                fit_reg, fit_next;
    logic [CNT_W-1:0]    vis_rows_reg, vis_rows_next;
    logic [ID_W-1:0]     tile_val_reg, tile_val_next;
    logic [SET_W-1:0]    set_idx_reg, set_idx_next;

    // shared divider
    logic [CAM_W-1:0]    div_q_reg, div_q_next;
    logic [TILE_W-1:0]   div_r_reg, div_r_next;
    logic [TILE_W-1:0]   div_d_reg, div_d_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [TILE_W:0]     div_shift;
    logic [TILE_W+1:0]   div_diff;
    logic                div_bit;

    // shared multiplier
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;

    // pending command
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic                res_draw_reg, res_draw_next;
    logic [SET_W-1:0]    res_set_reg, res_set_next;
    logic [SRC_W-1:0]    res_sx_reg, res_sx_next;
    logic [SRC_W-1:0]    res_sy_reg, res_sy_next;
    logic [DST_W-1:0]    res_dx_reg, res_dx_next;
    logic [DST_W-1:0]    res_dy_reg, res_dy_next;
    logic                res_done_reg, res_done_next;
    logic                out_load;

    // output register
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_draw_reg;
    logic [SET_W-1:0]    out_set_reg;
    logic [SRC_W-1:0]    out_sx_reg, out_sy_reg;
    logic [DST_W-1:0]    out_dx_reg, out_dy_reg;
    logic                out_done_reg;

    // tileset probe
    logic [15:0]         set_entry;
    logic [7:0]          set_cols, set_rows;
    logic                set_hit, set_last;

    // index update
    logic [INDEX_W-1:0]  pos_inc, tiles_dec;
    logic [CNT_W-1:0]    cc_inc;
    logic [CNT_W+1:0]    ceil_cnt;
    logic                row_end;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W+1:0] n);
        logic [CNT_W+1:0] lim;
        lim = {2'b00, {CNT_W{1'b1}}};
        return (n > lim) ? {CNT_W{1'b1}} : n[CNT_W-1:0];
    endfunction

    assign tw_eff = (tile_width_reg == '0) ? TILE_W'(1) : tile_width_reg;
    assign th_eff = (tile_height_reg == '0) ? TILE_W'(1) : tile_height_reg;

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == ST_IDLE);

    // restoring divider step
    assign div_shift = {div_r_reg, div_q_reg[CAM_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, div_d_reg};
    assign div_bit   = ~div_diff[TILE_W+1];

    assign set_entry = tileset_grid_reg[{set_idx_reg, 4'b0000} +: 16];
    assign set_cols  = set_entry[7:0];
    assign set_rows  = set_entry[15:8];
    assign set_last  = (int'(set_idx_reg) == NUM_TILESETS - 1);

    assign pos_inc   = fetch_pos_reg + INDEX_W'(1);
    assign cc_inc    = col_cnt_reg + CNT_W'(1);
    assign row_end   = (cc_inc == vis_cols_reg);
    assign tiles_dec = tiles_left_reg - INDEX_W'(1);
    assign ceil_cnt  = (CNT_W+2)'(div_q_reg[VIEW_W-1:0]) + (CNT_W+2)'(div_r_reg != '0);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_VCOL_MUL:
            begin
                mul_a = MUL_A_W'(map_columns_reg);
                mul_b = MUL_B_W'(tw_eff);
            end
            ST_VROW_MUL:
            begin
                mul_a = MUL_A_W'(map_rows_reg);
                mul_b = MUL_B_W'(th_eff);
            end
            ST_IDX_MUL:
            begin
                mul_a = div_q_reg;
                mul_b = map_columns_reg;
            end
            ST_CNT_MUL:
            begin
                mul_a = MUL_A_W'(vis_cols_reg);
                mul_b = MUL_B_W'(vis_rows_reg);
            end
            ST_SEARCH:
            begin
                mul_a = MUL_A_W'(set_cols);
                mul_b = MUL_B_W'(set_rows);
            end
            ST_SRC_X:
            begin
                mul_a = MUL_A_W'(div_r_reg);
                mul_b = MUL_B_W'(tw_eff);
            end
            ST_SRC_Y:
            begin
                mul_a = div_q_reg;
                mul_b = MUL_B_W'(th_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign set_hit = (set_cols != '0) && (MUL_P_W'(tile_val_reg) < mul_p);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        active_next     = active_reg;
        fetch_pos_next  = fetch_pos_reg;
        tiles_left_next = tiles_left_reg;
        col_cnt_next    = col_cnt_reg;
        vis_cols_next   = vis_cols_reg;
        screen_x_next   = screen_x_reg;
        screen_y_next   = screen_y_reg;
        cam_x_next      = cam_x_reg;
        cam_y_next      = cam_y_reg;
        fit_next        = fit_reg;
        vis_rows_next   = vis_rows_reg;
        tile_val_next   = tile_val_reg;
        set_idx_next    = set_idx_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_d_next      = div_d_reg;
        div_cnt_next    = div_cnt_reg;
        res_index_next  = res_index_reg;
        res_draw_next   = res_draw_reg;
        res_set_next    = res_set_reg;
        res_sx_next     = res_sx_reg;
        res_sy_next     = res_sy_reg;
        res_dx_next     = res_dx_reg;
        res_dy_next     = res_dy_reg;
        res_done_next   = res_done_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                res_draw_next = 1'b0;
                res_set_next  = '0;
                res_sx_next   = '0;
                res_sy_next   = '0;
                res_done_next = 1'b0;
                if (item.valid)
                begin
                    if (item.func == tmwf_pkg::FUNC_START)
                    begin
                        cam_x_next  = item.camera_x;
                        cam_y_next  = item.camera_y;
                        res_dx_next = '0;
                        res_dy_next = '0;
                        state_next  = ST_VCOL_MUL;
                    end
                    else if (active_reg)
                    begin
                        res_dx_next   = screen_x_reg;
                        res_dy_next   = screen_y_reg;
                        tile_val_next = item.tile_id - ID_W'(1);
                        set_idx_next  = '0;
                        state_next    = (item.tile_id == '0) ? ST_ADVANCE : ST_SEARCH;
                    end
                end
            end
            ST_VCOL_MUL:
            begin
                fit_next     = (mul_p >= MUL_P_W'(view_width_reg));
                div_q_next   = {view_width_reg, {(CAM_W-VIEW_W){1'b0}}};
                div_r_next   = '0;
                div_d_next   = tw_eff;
                div_cnt_next = DCNT_W'(VIEW_W);
                ret_next     = ST_VCOL;
                state_next   = ST_DIVIDE;
            end
            ST_VCOL:
            begin
                vis_cols_next = sat_count(fit_reg ? ceil_cnt : (CNT_W+2)'(map_columns_reg));
                state_next    = ST_VROW_MUL;
            end
            ST_VROW_MUL:
            begin
                fit_next     = (mul_p >= MUL_P_W'(view_height_reg));
                div_q_next   = {view_height_reg, {(CAM_W-VIEW_W){1'b0}}};
                div_r_next   = '0;
                div_d_next   = th_eff;
                div_cnt_next = DCNT_W'(VIEW_W);
                ret_next     = ST_VROW;
                state_next   = ST_DIVIDE;
            end
            ST_VROW:
            begin
                vis_rows_next = sat_count(fit_reg ? ceil_cnt : (CNT_W+2)'(map_rows_reg));
                div_q_next    = cam_y_reg;
                div_r_next    = '0;
                div_d_next    = th_eff;
                div_cnt_next  = DCNT_W'(CAM_W);
                ret_next      = ST_IDX_MUL;
                state_next    = ST_DIVIDE;
            end
            ST_IDX_MUL:
            begin
                fetch_pos_next = mul_p[INDEX_W-1:0];
                div_q_next     = cam_x_reg;
                div_r_next     = '0;
                div_d_next     = tw_eff;
                div_cnt_next   = DCNT_W'(CAM_W);
                ret_next       = ST_IDX_ADD;
                state_next     = ST_DIVIDE;
            end
            ST_IDX_ADD:
            begin
                fetch_pos_next = fetch_pos_reg + INDEX_W'(div_q_reg);
                state_next     = ST_CNT_MUL;
            end
            ST_CNT_MUL:
            begin
                tiles_left_next = mul_p[INDEX_W-1:0];
                active_next     = (mul_p[INDEX_W-1:0] != '0);
                col_cnt_next    = '0;
                screen_x_next   = '0;
                screen_y_next   = '0;
                res_index_next  = fetch_pos_reg;
                res_done_next   = (mul_p[INDEX_W-1:0] == '0);
                state_next      = ST_DONE;
            end
            ST_SEARCH:
            begin
                if (set_hit)
                begin
                    res_set_next = set_idx_reg;
                    div_q_next   = {tile_val_reg, {(CAM_W-ID_W){1'b0}}};
                    div_r_next   = '0;
                    div_d_next   = TILE_W'(set_cols);
                    div_cnt_next = DCNT_W'(ID_W);
                    ret_next     = ST_SRC_X;
                    state_next   = ST_DIVIDE;
                end
                else if (set_last)
                begin
                    state_next = ST_ADVANCE;
                end
                else
                begin
                    set_idx_next = set_idx_reg + SET_W'(1);
                end
            end
            ST_SRC_X:
            begin
                // remainder is the column inside the tileset
                res_sx_next = mul_p[SRC_W-1:0];
                state_next  = ST_SRC_Y;
            end
            ST_SRC_Y:
            begin
                res_sy_next   = mul_p[SRC_W-1:0];
                res_draw_next = 1'b1;
                state_next    = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                if (row_end)
                begin
                    fetch_pos_next = pos_inc + INDEX_W'(map_columns_reg)
                                   - INDEX_W'(vis_cols_reg);
                    col_cnt_next   = '0;
                    screen_x_next  = '0;
                    screen_y_next  = screen_y_reg + DST_W'(th_eff);
                end
                else
                begin
                    fetch_pos_next = pos_inc;
                    col_cnt_next   = cc_inc;
                    screen_x_next  = screen_x_reg + DST_W'(tw_eff);
                end
                tiles_left_next = tiles_dec;
                if (tiles_dec == '0)
                begin
                    active_next    = 1'b0;
                    res_done_next  = 1'b1;
                    res_index_next = '0;
                end
                else
                begin
                    res_index_next = fetch_pos_next;
                end
                state_next = ST_DONE;
            end
            ST_DIVIDE:
            begin
                div_q_next   = {div_q_reg[CAM_W-2:0], div_bit};
                div_r_next   = div_bit ? div_diff[TILE_W-1:0] : div_shift[TILE_W-1:0];
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = ret_reg;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ret_reg          <= ST_IDLE;
            active_reg       <= 1'b0;
            fetch_pos_reg    <= '0;
            tiles_left_reg   <= '0;
            col_cnt_reg      <= '0;
            vis_cols_reg     <= '0;
            screen_x_reg     <= '0;
            screen_y_reg     <= '0;
            out_valid_reg    <= 1'b0;
            tile_width_reg   <= TILE_W'(32);
            tile_height_reg  <= TILE_W'(32);
            map_columns_reg  <= MAP_W'(64);
            map_rows_reg     <= MAP_W'(64);
            view_width_reg   <= VIEW_W'(640);
            view_height_reg  <= VIEW_W'(480);
            tileset_grid_reg <= tmwf_pkg::GRID_W'(2056);
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            active_reg     <= active_next;
            fetch_pos_reg  <= fetch_pos_next;
            tiles_left_reg <= tiles_left_next;
            col_cnt_reg    <= col_cnt_next;
            vis_cols_reg   <= vis_cols_next;
            screen_x_reg   <= screen_x_next;
            screen_y_reg   <= screen_y_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                case (tmwf_pkg::cfg_reg_t'(cfg.index))
                    tmwf_pkg::REG_TILE_WIDTH:   tile_width_reg   <= cfg.data[TILE_W-1:0];
                    tmwf_pkg::REG_TILE_HEIGHT:  tile_height_reg  <= cfg.data[TILE_W-1:0];
                    tmwf_pkg::REG_MAP_COLUMNS:  map_columns_reg  <= cfg.data[MAP_W-1:0];
                    tmwf_pkg::REG_MAP_ROWS:     map_rows_reg     <= cfg.data[MAP_W-1:0];
                    tmwf_pkg::REG_VIEW_WIDTH:   view_width_reg   <= cfg.data[VIEW_W-1:0];
                    tmwf_pkg::REG_VIEW_HEIGHT:  view_height_reg  <= cfg.data[VIEW_W-1:0];
                    tmwf_pkg::REG_TILESET_GRID: tileset_grid_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cam_x_reg     <= cam_x_next;
        cam_y_reg     <= cam_y_next;
        fit_reg       <= fit_next;
        vis_rows_reg  <= vis_rows_next;
        tile_val_reg  <= tile_val_next;
        set_idx_reg   <= set_idx_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        div_d_reg     <= div_d_next;
        div_cnt_reg   <= div_cnt_next;
        res_index_reg <= res_index_next;
        res_draw_reg  <= res_draw_next;
        res_set_reg   <= res_set_next;
        res_sx_reg    <= res_sx_next;
        res_sy_reg    <= res_sy_next;
        res_dx_reg    <= res_dx_next;
        res_dy_reg    <= res_dy_next;
        res_done_reg  <= res_done_next;
        if (out_load)
        begin
            out_index_reg <= res_index_reg;
            out_draw_reg  <= res_draw_reg;
            out_set_reg   <= res_set_reg;
            out_sx_reg    <= res_sx_reg;
            out_sy_reg    <= res_sy_reg;
            out_dx_reg    <= res_dx_reg;
            out_dy_reg    <= res_dy_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.map_index      = out_index_reg;
    assign result.draw           = out_draw_reg;
    assign result.tileset_select = out_set_reg;
    assign result.source_x       = out_sx_reg;
    assign result.source_y       = out_sy_reg;
    assign result.dest_x         = out_dx_reg;
    assign result.dest_y         = out_dy_reg;
    assign result.frame_done     = out_done_reg;

endmodule

// ===== src/tmwf_checker.sv =====
// ----------------------------------------------------------------------------
// tmwf_checker
// Port-level checks of the tile-map window fetcher, bound to the top level.
// ----------------------------------------------------------------------------
module tmwf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_func,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tmwf_pkg::INDEX_W-1:0]  out_index,
    input logic                          out_draw,
    input logic [tmwf_pkg::SET_W-1:0]    out_set,
    input logic [tmwf_pkg::SRC_W-1:0]    out_sx,
    input logic [tmwf_pkg::SRC_W-1:0]    out_sy
);

    // a stalled command keeps its index and draw flag
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_draw))
        else $error("stalled result changed");

    // a start request always takes the sequencer busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == tmwf_pkg::FUNC_START) |=> !in_ready)
        else $error("ready after start request");

    // skipped tiles carry no tileset or source position
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_draw |-> (out_set == '0) && (out_sx == '0) && (out_sy == '0))
        else $error("skipped tile with source data");

    // a new result only comes out of a busy sequencer
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");

endmodule

bind tile_map_window_fetch tmwf_checker u_tmwf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_func   (item.func),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_index (result.map_index),
    .out_draw  (result.draw),
    .out_set   (result.tileset_select),
    .out_sx    (result.source_x),
    .out_sy    (result.source_y)
);

// ===== tb/tile_map_window_fetch_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_map_window_fetch_checker
// Watches the register, request and draw command channels of the tile-map
// window fetcher, keeps its own copy of the registers and the window walk,
// predicts every draw command and compares it field by field in order.
// ----------------------------------------------------------------------------
module tile_map_window_fetch_checker #(
    parameter int NUM_TILESETS = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    tmwf_cfg_if   cfg,
    tmwf_in_if    item,
    tmwf_out_if   result,
    output int    mismatch_count,
    output int    pending_cmds,
    output logic  frame_open
);

    localparam int TILE_W  = tmwf_pkg::TILE_W;
    localparam int MAP_W   = tmwf_pkg::MAP_W;
    localparam int VIEW_W  = tmwf_pkg::VIEW_W;
    localparam int GRID_W  = tmwf_pkg::GRID_W;
    localparam int CAM_W   = tmwf_pkg::CAM_W;
    localparam int ID_W    = tmwf_pkg::ID_W;
    localparam int INDEX_W = tmwf_pkg::INDEX_W;
    localparam int SRC_W   = tmwf_pkg::SRC_W;
    localparam int DST_W   = tmwf_pkg::DST_W;
    localparam int SET_W   = tmwf_pkg::SET_W;
    localparam int CNT_W   = tmwf_pkg::CNT_W;

    typedef struct packed {
        logic [INDEX_W-1:0] map_index;
        logic               draw;
        logic [SET_W-1:0]   tileset_select;
        logic [SRC_W-1:0]   source_x;
        logic [SRC_W-1:0]   source_y;
        logic [DST_W-1:0]   dest_x;
        logic [DST_W-1:0]   dest_y;
        logic               frame_done;
    } draw_cmd_t;

    draw_cmd_t expected_cmds[$];

    // register copy
    logic [TILE_W-1:0]  tile_w, tile_h;
    logic [MAP_W-1:0]   map_cols, map_rows;
    logic [VIEW_W-1:0]  view_w, view_h;
    logic [GRID_W-1:0]  grid;

    // window walk
    logic [INDEX_W-1:0] fetch_pos;
    logic [CNT_W-1:0]   col_cnt;
    logic [DST_W-1:0]   scr_x, scr_y;
    logic [INDEX_W-1:0] tiles_left;
    logic [CNT_W-1:0]   vis_cols;
    logic               frame_on;

    function automatic logic [CNT_W-1:0] visible_span(input longint unsigned map_tiles,
                                                      input longint unsigned tile,
                                                      input longint unsigned view);
        longint unsigned n;
        if (map_tiles * tile >= view)
            n = (view + tile - 1) / tile;
        else
            n = map_tiles;
        return (n > 4095) ? 12'd4095 : n[CNT_W-1:0];
    endfunction

    function automatic void predict_draw_cmd(input logic func, input logic [CAM_W-1:0] cx,
                                             input logic [CAM_W-1:0] cy,
                                             input logic [ID_W-1:0] id);
        int unsigned     tw, th, val, cols, rws, row, col;
        longint unsigned first;
        logic [CNT_W-1:0] rows;
        draw_cmd_t       cmd;
        bit              hit;
        tw  = (tile_w == 0) ? 1 : tile_w;
        th  = (tile_h == 0) ? 1 : tile_h;
        cmd = '0;
        hit = 1'b0;
        if (func == tmwf_pkg::FUNC_START) begin
            rows       = visible_span(map_rows, th, view_h);
            vis_cols   = visible_span(map_cols, tw, view_w);
            tiles_left = vis_cols * rows;
            first      = longint'(cy / th) * map_cols + cx / tw;
            fetch_pos  = first[INDEX_W-1:0];
            col_cnt    = '0;
            scr_x      = '0;
            scr_y      = '0;
            frame_on   = (tiles_left != 0);
            cmd.map_index  = fetch_pos;
            cmd.frame_done = !frame_on;
            expected_cmds = {expected_cmds, cmd};
        end else if (frame_on) begin
            cmd.dest_x = scr_x;
            cmd.dest_y = scr_y;
            if (id != 0) begin
                val = id - 1;
                // first tileset large enough wins; zero columns means absent
                for (int i = 0; i < NUM_TILESETS; i++) begin
                    cols = grid[16*i +: 8];
                    rws  = grid[16*i+8 +: 8];
                    if (!hit && cols != 0 && val < cols * rws) begin
                        hit = 1'b1;
                        row = val / cols;
                        col = val - row * cols;
                        cmd.draw           = 1'b1;
                        cmd.tileset_select = SET_W'(i);
                        cmd.source_x       = SRC_W'(col * tw);
                        cmd.source_y       = SRC_W'(row * th);
                    end
                end
            end
            fetch_pos = fetch_pos + 1'b1;
            col_cnt   = col_cnt + 1'b1;
            scr_x     = scr_x + DST_W'(tw);
            if (col_cnt == vis_cols) begin
                fetch_pos = fetch_pos + INDEX_W'(map_cols) - INDEX_W'(vis_cols);
                col_cnt   = '0;
                scr_x     = '0;
                scr_y     = scr_y + DST_W'(th);
            end
            tiles_left = tiles_left - 1'b1;
            if (tiles_left == 0) begin
                frame_on       = 1'b0;
                cmd.frame_done = 1'b1;
                cmd.map_index  = '0;
            end else begin
                cmd.map_index = fetch_pos;
            end
            expected_cmds = {expected_cmds, cmd};
        end
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        draw_cmd_t want;
        if (!rst_n) begin
            tile_w     = 9'd32;
            tile_h     = 9'd32;
            map_cols   = 13'd64;
            map_rows   = 13'd64;
            view_w     = 13'd640;
            view_h     = 13'd480;
            grid       = 64'd2056;
            fetch_pos  = '0;
            col_cnt    = '0;
            scr_x      = '0;
            scr_y      = '0;
            tiles_left = '0;
            vis_cols   = '0;
            frame_on   = 1'b0;
            expected_cmds.delete();
            pending_cmds = 0;
            frame_open   = 1'b0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (tmwf_pkg::cfg_reg_t'(cfg.index))
                    tmwf_pkg::REG_TILE_WIDTH:   tile_w   = cfg.data[TILE_W-1:0];
                    tmwf_pkg::REG_TILE_HEIGHT:  tile_h   = cfg.data[TILE_W-1:0];
                    tmwf_pkg::REG_MAP_COLUMNS:  map_cols = cfg.data[MAP_W-1:0];
                    tmwf_pkg::REG_MAP_ROWS:     map_rows = cfg.data[MAP_W-1:0];
                    tmwf_pkg::REG_VIEW_WIDTH:   view_w   = cfg.data[VIEW_W-1:0];
                    tmwf_pkg::REG_VIEW_HEIGHT:  view_h   = cfg.data[VIEW_W-1:0];
                    tmwf_pkg::REG_TILESET_GRID: grid     = cfg.data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t: draw command with none outstanding, map_index %0h",
                                 $realtime, result.map_index);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("map_index", want.map_index, result.map_index);
                    check_field("draw", want.draw, result.draw);
                    check_field("tileset_select", want.tileset_select, result.tileset_select);
                    check_field("source_x", want.source_x, result.source_x);
                    check_field("source_y", want.source_y, result.source_y);
                    check_field("dest_x", want.dest_x, result.dest_x);
                    check_field("dest_y", want.dest_y, result.dest_y);
                    check_field("frame_done", want.frame_done, result.frame_done);
                end
            end
            if (item.valid && item.ready)
                predict_draw_cmd(item.func, item.camera_x, item.camera_y, item.tile_id);
            pending_cmds = expected_cmds.size();
            frame_open   = frame_on;
        end
    end

endmodule

// ===== tb/tile_map_window_fetch_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_map_window_fetch_tb
// Drives register writes, frame starts and tile id requests into the tile-map
// window fetcher: a directed part for the corner cases, then random map, view
// and tileset settings with random windows, ids and handshake gaps. The
// checker beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tile_map_window_fetch_tb;

    localparam int TILE_W = tmwf_pkg::TILE_W;
    localparam int MAP_W  = tmwf_pkg::MAP_W;
    localparam int VIEW_W = tmwf_pkg::VIEW_W;
    localparam int GRID_W = tmwf_pkg::GRID_W;
    localparam int CAM_W  = tmwf_pkg::CAM_W;
    localparam int ID_W   = tmwf_pkg::ID_W;

    typedef struct packed {
        logic [TILE_W-1:0] tile_w;
        logic [TILE_W-1:0] tile_h;
        logic [MAP_W-1:0]  map_cols;
        logic [MAP_W-1:0]  map_rows;
        logic [VIEW_W-1:0] view_w;
        logic [VIEW_W-1:0] view_h;
        logic [GRID_W-1:0] grid;
    } cfg_set_t;

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          pending_cmds;
    logic        frame_open;
    int unsigned items_sent;
    bit          calm_tx;
    bit          calm_rx;
    int          rx_hold;

    tmwf_cfg_if cfg_ch ();
    tmwf_in_if  item_ch ();
    tmwf_out_if result_ch ();

    tile_map_window_fetch #(
        .NUM_TILESETS (4)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    tile_map_window_fetch_checker #(
        .NUM_TILESETS (4)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .item           (item_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .pending_cmds   (pending_cmds),
        .frame_open     (frame_open)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // draw command sink: random stall per command, or a long hold on request
    initial
    begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm_rx ? 0 : $urandom_range(0, 16);
            if (rx_hold != 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("[tile_map_window_fetch] ERROR");
        $finish;
    end

    function automatic logic [CAM_W-1:0] pick_camera();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CAM_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_tile_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom_range(1, 16));
            4, 5, 6: return ID_W'($urandom_range(1, 300));
            7:       return ID_W'($urandom_range(1, 3000));
            default: return ID_W'($urandom);
        endcase
    endfunction

    function automatic logic [TILE_W-1:0] pick_tile_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 9'd256;
            2:       return TILE_W'($urandom_range(257, 511));
            default: return TILE_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_tileset();
        case ($urandom_range(0, 5))
            0:       return {8'($urandom), 8'h00};
            1:       return 16'($urandom);
            default: return {8'($urandom_range(0, 12)), 8'($urandom_range(1, 12))};
        endcase
    endfunction

    // small windows: at most 6 x 5 tiles, sometimes clipped by the map or empty
    task automatic random_config(output cfg_set_t s);
        int          cols_vis, rows_vis;
        int unsigned tw_e, th_e;
        s.tile_w = pick_tile_size();
        s.tile_h = pick_tile_size();
        tw_e     = (s.tile_w == 0) ? 1 : s.tile_w;
        th_e     = (s.tile_h == 0) ? 1 : s.tile_h;
        cols_vis = $urandom_range(1, 6);
        rows_vis = $urandom_range(1, 5);
        s.view_w = VIEW_W'((cols_vis - 1) * tw_e + $urandom_range(1, tw_e));
        s.view_h = VIEW_W'((rows_vis - 1) * th_e + $urandom_range(1, th_e));
        s.map_cols = ($urandom_range(0, 4) == 0) ? MAP_W'($urandom_range(0, cols_vis))
                                                 : MAP_W'($urandom_range(cols_vis, 8191));
        s.map_rows = ($urandom_range(0, 4) == 0) ? MAP_W'($urandom_range(0, rows_vis))
                                                 : MAP_W'($urandom_range(rows_vis, 8191));
        if ($urandom_range(0, 15) == 0)
            s.view_w = '0;
        for (int i = 0; i < 4; i++)
            s.grid[16*i +: 16] = pick_tileset();
    endtask

    // sender pause: hold off until every outstanding command has come back
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_cmds != 0);
    endtask

    task automatic write_reg(input tmwf_pkg::cfg_reg_t idx, input logic [GRID_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic load_config(input cfg_set_t s);
        quiesce();
        // an ignored tile request may still be in progress
        repeat (50) @(negedge clk);
        write_reg(tmwf_pkg::REG_TILE_WIDTH, GRID_W'(s.tile_w));
        write_reg(tmwf_pkg::REG_TILE_HEIGHT, GRID_W'(s.tile_h));
        write_reg(tmwf_pkg::REG_MAP_COLUMNS, GRID_W'(s.map_cols));
        write_reg(tmwf_pkg::REG_MAP_ROWS, GRID_W'(s.map_rows));
        write_reg(tmwf_pkg::REG_VIEW_WIDTH, GRID_W'(s.view_w));
        write_reg(tmwf_pkg::REG_VIEW_HEIGHT, GRID_W'(s.view_h));
        write_reg(tmwf_pkg::REG_TILESET_GRID, s.grid);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input tmwf_pkg::func_t f, input logic [CAM_W-1:0] cx,
                             input logic [CAM_W-1:0] cy, input logic [ID_W-1:0] id);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 16);
        if (f == tmwf_pkg::FUNC_START || frame_open)
            items_sent++;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.func     <= f;
        item_ch.camera_x <= cx;
        item_ch.camera_y <= cy;
        item_ch.tile_id  <= id;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic start_frame(input logic [CAM_W-1:0] cx, input logic [CAM_W-1:0] cy);
        send_item(tmwf_pkg::FUNC_START, cx, cy, ID_W'($urandom));
    endtask

    task automatic send_tile(input logic [ID_W-1:0] id);
        send_item(tmwf_pkg::FUNC_TILE, CAM_W'($urandom), CAM_W'($urandom), id);
    endtask

    initial
    begin : stimulus
        cfg_set_t cur_cfg;
        int       phase;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        item_ch.valid    = 1'b0;
        item_ch.func     = 1'b0;
        item_ch.camera_x = '0;
        item_ch.camera_y = '0;
        item_ch.tile_id  = '0;
        calm_tx          = 1'b0;
        calm_rx          = 1'b0;
        rx_hold          = 0;
        items_sent       = 0;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: 20 x 15 window, one 8 x 8 tileset
        send_tile(15'd5);
        start_frame('1, '1);
        send_tile(15'd0);
        send_tile(15'd1);
        send_tile(15'd64);
        send_tile(15'd65);
        send_tile('1);
        start_frame('0, '0);
        send_tile(15'd8);
        send_tile(15'd57);

        // 3 x 2 window, first tileset absent, ids in the second and last tilesets
        load_config('{9'd16, 9'd8, 13'd3, 13'd2, 13'd40, 13'd9, 64'hFFFF_0103_0202_0500});
        start_frame(20'd100, 20'd30);
        send_tile(15'd4);
        send_tile(15'd5);
        send_tile(15'd7);
        send_tile(15'd8);
        send_tile(15'd0);
        send_tile('1);
        send_tile(15'd3);

        // zero tile sizes act as one; map narrower than the view; no tilesets
        load_config('{9'd0, 9'd0, 13'd2, 13'd8191, 13'd8191, 13'd1, 64'h0});
        start_frame(20'd3, 20'd5);
        send_tile(15'd1);
        send_tile(15'd2);

        // zero map width and zero view height: nothing visible
        load_config('{9'd0, 9'd0, 13'd0, 13'd8191, 13'd100, 13'd0, 64'h0});
        start_frame(20'd7, 20'd9);
        send_tile(15'd1);

        // column count saturates at 4095
        load_config('{9'd1, 9'd256, 13'd4096, 13'd1, 13'd4096, 13'd1, '1});
        start_frame(20'h12345, 20'd0);
        send_tile(15'd1);
        send_tile(15'd2);

        phase = 0;
        while (items_sent < 850)
        begin
            random_config(cur_cfg);
            load_config(cur_cfg);
            repeat ($urandom_range(1, 3))
            begin
                calm_tx = ($urandom_range(0, 3) == 0);
                calm_rx = ($urandom_range(0, 3) == 0);
                if (phase % 7 == 2)
                    rx_hold = 300;
                if (!frame_open && $urandom_range(0, 5) == 0)
                    send_tile(pick_tile_id());
                start_frame(pick_camera(), pick_camera());
                while (frame_open)
                begin
                    if ($urandom_range(0, 24) == 0)
                        start_frame(pick_camera(), pick_camera());
                    else
                        send_tile(pick_tile_id());
                end
                if ($urandom_range(0, 2) == 0)
                    quiesce();
            end
            phase++;
        end

        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_cmds != 0);
        repeat (100) @(negedge clk);
        if (mismatch_count == 0)
            $display("[tile_map_window_fetch] OK");
        else
            $display("[tile_map_window_fetch] ERROR");
        $finish;
    end

endmodule

// ===== tile_map_window_fetch.f =====
src/tmwf_pkg.sv
src/tmwf_cfg_if.sv
src/tmwf_in_if.sv
src/tmwf_out_if.sv
src/tile_map_window_fetch.sv
src/tmwf_checker.sv
tb/tile_map_window_fetch_checker.sv
tb/tile_map_window_fetch_tb.sv
